### hw/rtl/acm_pkg.sv
// Shared types, widths and codes for the Aho-Corasick stream matcher.
// No dependencies; every other file in hw/rtl imports this package.
package acm_pkg;

    // Field widths of the input and result words.
    localparam int unsigned MODE_W = 2;
    localparam int unsigned NODE_W = 10;
    localparam int unsigned SYM_W  = 8;
    localparam int unsigned VAL_W  = 32;

    // Default sizing handed to the top level.
    localparam int unsigned NODE_COUNT_DEF  = 1024;
    localparam int unsigned MAX_MATCHES_DEF = 32;

    // Mode codes carried by an input word.
    localparam logic [MODE_W-1:0] MODE_TRANS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ATTR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd2;

    // The automaton root.
    localparam logic [NODE_W-1:0] ROOT_NODE = 10'd1;

    // Requests from the sequencer to the automaton tables.
    typedef struct packed {
        logic                     tr_we;
        logic                     tr_re;
        logic                     at_we;
        logic                     at_re;
        logic [NODE_W-1:0]        wr_node;
        logic [SYM_W-1:0]         wr_sym;
        logic [NODE_W-1:0]        wr_target;
        logic                     wr_end;
        logic [NODE_W-1:0]        wr_link;
        logic signed [VAL_W-1:0]  wr_value;
        logic [NODE_W-1:0]        tr_rd_node;
        logic [SYM_W-1:0]         tr_rd_sym;
        logic [NODE_W-1:0]        at_rd_node;
    } t_tbl_req;

    // Registered read data from the automaton tables.
    typedef struct packed {
        logic [NODE_W-1:0]        next_node;
        logic                     end_flag;
        logic [NODE_W-1:0]        link;
        logic signed [VAL_W-1:0]  value;
    } t_tbl_rsp;

endpackage

### hw/rtl/aho_corasick_stream_matcher.sv
// Aho-Corasick stream matcher. A load word is written into its table as it
// is accepted. A byte word that matches nothing takes a transition memory
// read, an attribute read and a decision, in that order. Each end-node hop of
// the link walk adds a step for its match, and so does each hop through a
// non-end node; the two tables have registered reads. Results leave through
// an output register. Synchronous reset returns the active node to the root;
// the tables are not cleared and must be loaded before use.
module aho_corasick_stream_matcher #(
    parameter int unsigned NODE_COUNT  = acm_pkg::NODE_COUNT_DEF,
    parameter int unsigned MAX_MATCHES = acm_pkg::MAX_MATCHES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [acm_pkg::MODE_W-1:0]         i_in_mode,
    input  logic [acm_pkg::NODE_W-1:0]         i_in_node_index,
    input  logic [acm_pkg::SYM_W-1:0]          i_in_symbol,
    input  logic [acm_pkg::NODE_W-1:0]         i_in_target_node,
    input  logic                               i_in_end_flag,
    input  logic [acm_pkg::NODE_W-1:0]         i_in_link_node,
    input  logic signed [acm_pkg::VAL_W-1:0]   i_in_pattern_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_out_match_found,
    output logic signed [acm_pkg::VAL_W-1:0]   o_out_match_value,
    output logic [acm_pkg::NODE_W-1:0]         o_out_current_node,
    output logic                               o_out_truncated,
    output logic                               o_out_last
);
    import acm_pkg::*;

    localparam int unsigned CW = $clog2(MAX_MATCHES + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_TRANS = 3'b010,
        S_EVAL  = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [NODE_W-1:0]        r_active, n_active;
    logic [NODE_W-1:0]        r_cur, n_cur;
    logic                     r_phase1, n_phase1;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_pend_valid, n_pend_valid;
    logic signed [VAL_W-1:0]  r_pend_value, n_pend_value;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_found, n_out_found;
    logic signed [VAL_W-1:0]  r_out_value, n_out_value;
    logic [NODE_W-1:0]        r_out_node, n_out_node;
    logic                     r_out_trunc, n_out_trunc;
    logic                     r_out_last, n_out_last;

    t_tbl_req                 tbl_req;
    t_tbl_rsp                 tbl_rsp;
    logic                     in_acc;
    logic                     out_free;
    logic [NODE_W-1:0]        cand;
    logic                     sat;

    acm_tables #(
        .NODE_COUNT (NODE_COUNT)
    ) u_tables (
        .i_clk (i_clk),
        .i_req (tbl_req),
        .o_rsp (tbl_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Node to check next: the current node if it is an end node or was reached by a hop, otherwise its link.
    assign cand = (r_phase1 || tbl_rsp.end_flag) ? r_cur : tbl_rsp.link;
    assign sat  = (r_count == CW'(MAX_MATCHES));

    // Sequencer: table writes for load words; for a byte word, a transition step, then a walk along the suffix links.
    always_comb begin
        n_state      = r_state;
        n_active     = r_active;
        n_cur        = r_cur;
        n_phase1     = r_phase1;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_value = r_pend_value;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_found  = r_out_found;
        n_out_value  = r_out_value;
        n_out_node   = r_out_node;
        n_out_trunc  = r_out_trunc;
        n_out_last   = r_out_last;

        tbl_req            = '0;
        tbl_req.wr_node    = i_in_node_index;
        tbl_req.wr_sym     = i_in_symbol;
        tbl_req.wr_target  = i_in_target_node;
        tbl_req.wr_end     = i_in_end_flag;
        tbl_req.wr_link    = i_in_link_node;
        tbl_req.wr_value   = i_in_pattern_value;
        tbl_req.tr_rd_node = r_active;
        tbl_req.tr_rd_sym  = i_in_symbol;
        tbl_req.at_rd_node = r_cur;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_mode)
                        MODE_TRANS: tbl_req.tr_we = 1'b1;
                        MODE_ATTR:  tbl_req.at_we = 1'b1;
                        MODE_CHAR: begin
                            tbl_req.tr_re = 1'b1;
                            n_state       = S_TRANS;
                        end
                        default: ;
                    endcase
                end
            end
            S_TRANS: begin
                // Step the active node and fetch the attributes of the new node.
                n_active           = tbl_rsp.next_node;
                n_cur              = tbl_rsp.next_node;
                tbl_req.at_rd_node = tbl_rsp.next_node;
                tbl_req.at_re      = 1'b1;
                n_phase1           = 1'b0;
                n_count            = '0;
                n_pend_valid       = 1'b0;
                n_state            = S_EVAL;
            end
            S_EVAL: begin
                if (!r_phase1 && ((cand == ROOT_NODE) || sat)) begin
                    // End of the run: the held report, or a no-match word if none is held, goes out as the last one.
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_node   = r_active;
                        n_out_last   = 1'b1;
                        n_out_found  = r_pend_valid;
                        n_out_value  = r_pend_valid ? r_pend_value : '0;
                        n_out_trunc  = r_pend_valid && (cand != ROOT_NODE);
                        n_pend_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else if (!r_phase1 && !tbl_rsp.end_flag) begin
                    // Hop through a non-end node to its link.
                    n_cur              = tbl_rsp.link;
                    tbl_req.at_rd_node = tbl_rsp.link;
                    tbl_req.at_re      = 1'b1;
                    n_phase1           = 1'b1;
                end else if (!r_pend_valid || out_free) begin
                    // Report this node; the previous report goes out first.
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_node  = r_active;
                        n_out_last  = 1'b0;
                        n_out_found = 1'b1;
                        n_out_value = r_pend_value;
                        n_out_trunc = 1'b0;
                    end
                    n_pend_valid       = 1'b1;
                    n_pend_value       = tbl_rsp.value;
                    n_count            = r_count + 1'b1;
                    n_cur              = tbl_rsp.link;
                    tbl_req.at_rd_node = tbl_rsp.link;
                    tbl_req.at_re      = 1'b1;
                    n_phase1           = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= ROOT_NODE;
            r_phase1     <= 1'b0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_phase1     <= n_phase1;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_pend_value <= n_pend_value;
        r_out_found  <= n_out_found;
        r_out_value  <= n_out_value;
        r_out_node   <= n_out_node;
        r_out_trunc  <= n_out_trunc;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_match_found  = r_out_found;
    assign o_out_match_value  = r_out_value;
    assign o_out_current_node = r_out_node;
    assign o_out_truncated    = r_out_trunc;
    assign o_out_last         = r_out_last;

    // The match count never passes its limit.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_MATCHES))
        else $error("match count above limit");

    // A held report exists only during the link walk.
    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == S_EVAL))
        else $error("held report outside link walk");

    // The transition step follows only an accepted byte word.
    a_trans_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRANS) |-> $past(in_acc && (i_in_mode == MODE_CHAR)))
        else $error("transition step without a byte word");

    // A truncated word is always a match and the last of its run.
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_truncated) |-> (o_out_last && o_out_match_found))
        else $error("truncated word not last");

endmodule

### hw/rtl/acm_tables.sv
// Automaton storage: the transition memory and the node attribute memory.
// Depends on acm_pkg for widths and the request and response structs.
module acm_tables #(
    parameter int unsigned NODE_COUNT = acm_pkg::NODE_COUNT_DEF
) (
    input  logic              i_clk,
    input  acm_pkg::t_tbl_req i_req,
    output acm_pkg::t_tbl_rsp o_rsp
);
    import acm_pkg::*;

    // Only nodes that fit in the node field can ever be addressed.
    localparam int unsigned DEPTH    = (NODE_COUNT < (2 ** NODE_W)) ? NODE_COUNT : (2 ** NODE_W);
    localparam int unsigned AW       = $clog2(DEPTH);
    localparam int unsigned TR_DEPTH = DEPTH * (2 ** SYM_W);
    localparam int unsigned ATTR_W   = 1 + NODE_W + VAL_W;

    logic [NODE_W-1:0] m_trans [TR_DEPTH];
    logic [ATTR_W-1:0] m_attr  [DEPTH];

    logic              wr_ok;
    logic              tr_rd_ok;
    logic              at_rd_ok;
    logic [NODE_W-1:0] r_tr_data;
    logic              r_tr_oor;
    logic [ATTR_W-1:0] r_at_data;
    logic              r_at_oor;

    // Nodes at or beyond the node count are not stored.
    assign wr_ok    = (32'(i_req.wr_node) < DEPTH);
    assign tr_rd_ok = (32'(i_req.tr_rd_node) < DEPTH);
    assign at_rd_ok = (32'(i_req.at_rd_node) < DEPTH);

    // Transition memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.tr_we && wr_ok) begin
            m_trans[{i_req.wr_node[AW-1:0], i_req.wr_sym}] <= i_req.wr_target;
        end
        if (i_req.tr_re) begin
            r_tr_data <= m_trans[{i_req.tr_rd_node[AW-1:0], i_req.tr_rd_sym}];
            r_tr_oor  <= !tr_rd_ok;
        end
    end

    // Attribute memory holds end flag, suffix link and value of each node.
    always_ff @(posedge i_clk) begin
        if (i_req.at_we && wr_ok) begin
            m_attr[i_req.wr_node[AW-1:0]] <= {i_req.wr_end, i_req.wr_link, i_req.wr_value};
        end
        if (i_req.at_re) begin
            r_at_data <= m_attr[i_req.at_rd_node[AW-1:0]];
            r_at_oor  <= !at_rd_ok;
        end
    end

    // A node outside the table reads as all zeros.
    always_comb begin
        o_rsp.next_node = r_tr_oor ? '0 : r_tr_data;
        if (r_at_oor) begin
            o_rsp.end_flag = 1'b0;
            o_rsp.link     = '0;
            o_rsp.value    = '0;
        end else begin
            o_rsp.end_flag = r_at_data[ATTR_W-1];
            o_rsp.link     = r_at_data[ATTR_W-2 -: NODE_W];
            o_rsp.value    = r_at_data[VAL_W-1:0];
        end
    end

endmodule
